// File: src/mcm_pkg.sv
// Shared types and constants of the controller-change mapping table.
package mcm_pkg;

   // Operation codes carried on req_func
   localparam logic [2:0] FUNC_APPLY  = 3'd0;
   localparam logic [2:0] FUNC_LEARN  = 3'd1;
   localparam logic [2:0] FUNC_ARM    = 3'd2;
   localparam logic [2:0] FUNC_DISARM = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;

   localparam int unsigned MATCH_W = 5;

   // Upper end of the armed range after reset: 1.0 in Q16.16
   localparam logic signed [31:0] ARM_HIGH_RESET = 32'sh0001_0000;

   typedef struct packed {
      logic [4:0]         channel;
      logic [6:0]         ctrl;
      logic [7:0]         target;
      logic signed [31:0] low;
      logic signed [31:0] high;
   } entry_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] low;
      logic signed [31:0] high;
      logic [6:0]         value;
   } scale_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] result;
   } scale_rsp_type;

endpackage

// File: src/mcm_scale.sv
// Iterative range scaler: low + round(value * (high - low) / 127), saturated.
module mcm_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  mcm_pkg::scale_req_type scale_req,
   output mcm_pkg::scale_rsp_type scale_rsp
);
   import mcm_pkg::*;

   localparam logic [1:0] SC_IDLE = 2'd0;
   localparam logic [1:0] SC_MUL  = 2'd1;
   localparam logic [1:0] SC_DIV  = 2'd2;
   localparam logic [1:0] SC_FIN  = 2'd3;

   // six radix-128 digits cover the 42-bit dividend
   localparam logic [2:0] LAST_DIGIT = 3'd5;
   localparam logic [7:0] DIVISOR    = 8'd127;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         digit_ff, digit_in;
   logic signed [31:0] lo_ff;
   logic signed [32:0] diff_ff;
   logic [6:0]         value_ff;
   logic               neg_ff;
   logic [41:0]        dividend_ff, dividend_in;
   logic [6:0]         rem_ff, rem_in;
   logic [41:0]        quo_ff, quo_in;
   logic               done_ff;
   logic signed [31:0] result_ff, result_in;

   logic signed [40:0] product;
   logic [40:0]        magnitude;
   logic [7:0]         digit_sum;
   logic               corr;
   logic [6:0]         quo_digit;
   logic signed [33:0] quo_signed;
   logic signed [34:0] total;

   always_comb begin
      product   = $signed({1'b0, value_ff}) * diff_ff;
      magnitude = product[40] ? 41'(-product) : 41'(product);

      digit_sum = {1'b0, rem_ff} + {1'b0, dividend_ff[41:35]};
      corr      = digit_sum >= DIVISOR;
      quo_digit = rem_ff + 7'(corr);

      quo_signed = neg_ff ? -$signed(quo_ff[33:0]) : $signed(quo_ff[33:0]);
      total      = {{3{lo_ff[31]}}, lo_ff} + {quo_signed[33], quo_signed};
   end

   always_comb begin
      state_in    = state_ff;
      digit_in    = digit_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      result_in   = result_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (scale_req.start) begin
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            // add half the divisor so the truncating division rounds to nearest
            dividend_in = 42'(magnitude) + 42'd63;
            rem_in      = '0;
            quo_in      = '0;
            digit_in    = '0;
            state_in    = SC_DIV;
         end
         SC_DIV: begin
            rem_in      = corr ? 7'(digit_sum - DIVISOR) : digit_sum[6:0];
            quo_in      = {quo_ff[34:0], quo_digit};
            dividend_in = {dividend_ff[34:0], 7'd0};
            digit_in    = digit_ff + 3'd1;
            if (digit_ff == LAST_DIGIT) begin
               state_in = SC_FIN;
            end
         end
         SC_FIN: begin
            if (total > 35'sd2147483647) begin
               result_in = 32'sh7FFF_FFFF;
            end else if (total < -35'sd2147483648) begin
               result_in = 32'sh8000_0000;
            end else begin
               result_in = total[31:0];
            end
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == SC_FIN);
      end
      digit_ff    <= digit_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      result_ff   <= result_in;
      if (state_ff == SC_IDLE && scale_req.start) begin
         lo_ff    <= scale_req.low;
         diff_ff  <= {scale_req.high[31], scale_req.high} - {scale_req.low[31], scale_req.low};
         value_ff <= scale_req.value;
      end
      if (state_ff == SC_MUL) begin
         neg_ff <= product[40];
      end
   end

   assign scale_rsp.done   = done_ff;
   assign scale_rsp.result = result_ff;

endmodule

// File: src/midi_cc_map_table.sv
// Top level of the controller-change mapping table with learn mode.
//
//  channel   handshake          payload
//  -------   ----------------   --------------------------------------------------
//  req       req_valid/ready    func, channel, ctrl_number, ctrl_value, target_id,
//                               range_min, range_max
//  rsp       rsp_valid/ready    is_summary, out_target, scaled_value, match_count,
//                               ok, last
//
//  Arm, disarm, clear and unused codes go from idle straight to the summary beat.
//  Apply and learn walk the table one entry at a time, read then check, through the
//  registered read port; each apply match runs the shared scaler (multiply, six
//  radix-128 division digits, saturating add); done is seen, then the beat loaded.
//  The table handles one item at a time.
//  Reset is synchronous and empties the table and disarms; no clearing pass.
//  A stalled rsp holds the walk before the next beat; req is taken only when idle.
module midi_cc_map_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [4:0]  req_channel,
   input  logic [6:0]  req_ctrl_number,
   input  logic [6:0]  req_ctrl_value,
   input  logic [7:0]  req_target_id,
   input  logic signed [31:0] req_range_min,
   input  logic signed [31:0] req_range_max,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_is_summary,
   output logic [7:0]  rsp_out_target,
   output logic signed [31:0] rsp_scaled_value,
   output logic [4:0]  rsp_match_count,
   output logic        rsp_ok,
   output logic        rsp_last
);
   import mcm_pkg::*;

   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;
   localparam logic [2:0] ST_SUM   = 3'd5;

   // table memory, one packed entry per row
   entry_type table_mem [TABLE_ENTRIES];
   entry_type rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   entry_type         mem_wdata;

   logic [2:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [MATCH_W-1:0] match_ff, match_in;
   logic               sum_ok_ff, sum_ok_in;
   logic [7:0]         armed_target_ff, armed_target_in;
   logic signed [31:0] armed_low_ff, armed_low_in;
   logic signed [31:0] armed_high_ff, armed_high_in;

   // latched beat
   logic [2:0] op_ff;
   logic [4:0] chan_ff;
   logic [6:0] ctrl_ff;
   logic [6:0] value_ff;

   // output register
   logic               rsp_valid_ff;
   logic               rsp_is_summary_ff;
   logic [7:0]         rsp_out_target_ff;
   logic signed [31:0] rsp_scaled_value_ff;
   logic [4:0]         rsp_match_count_ff;
   logic               rsp_ok_ff;
   logic               rsp_last_ff;
   logic               load_match, load_sum;

   scale_req_type scale_req;
   scale_rsp_type scale_rsp;

   logic accept, slot_free, hit, walk_end;

   mcm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .scale_req (scale_req),
      .scale_rsp (scale_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign walk_end  = (idx_ff == count_ff);
   // an entry with channel zero listens on every channel
   assign hit = (rd_data_ff.ctrl == ctrl_ff) &&
                (rd_data_ff.channel == 5'd0 || rd_data_ff.channel == chan_ff);

   assign scale_req.start = (state_ff == ST_CHECK) && (op_ff == FUNC_APPLY) && hit;
   assign scale_req.low   = rd_data_ff.low;
   assign scale_req.high  = rd_data_ff.high;
   assign scale_req.value = value_ff;

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      idx_in          = idx_ff;
      match_in        = match_ff;
      sum_ok_in       = sum_ok_ff;
      armed_target_in = armed_target_ff;
      armed_low_in    = armed_low_ff;
      armed_high_in   = armed_high_ff;
      mem_we          = 1'b0;
      mem_waddr       = idx_ff[IDX_W-1:0];
      mem_wdata       = '{channel: chan_ff, ctrl: ctrl_ff, target: armed_target_ff,
                          low: armed_low_ff, high: armed_high_ff};
      load_match      = 1'b0;
      load_sum        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in    = '0;
               match_in  = '0;
               sum_ok_in = 1'b1;
               state_in  = ST_SUM;
               case (req_func)
                  FUNC_APPLY: begin
                     state_in = ST_READ;
                  end
                  FUNC_LEARN: begin
                     // nothing armed: fail without touching the table
                     if (armed_target_ff == 8'd0) begin
                        sum_ok_in = 1'b0;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  FUNC_ARM: begin
                     armed_target_in = req_target_id;
                     if (req_target_id != 8'd0) begin
                        armed_low_in  = req_range_min;
                        armed_high_in = req_range_max;
                     end
                  end
                  FUNC_DISARM: begin
                     armed_target_in = 8'd0;
                  end
                  FUNC_CLEAR: begin
                     armed_target_in = 8'd0;
                     count_in        = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            if (walk_end) begin
               state_in = ST_SUM;
               if (op_ff == FUNC_LEARN) begin
                  // target absent: append, or fail when the table is full
                  armed_target_in = 8'd0;
                  if (count_ff == FULL_COUNT) begin
                     sum_ok_in = 1'b0;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (op_ff == FUNC_APPLY) begin
               if (hit) begin
                  state_in = ST_WAIT;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_READ;
               end
            end else if (rd_data_ff.target == armed_target_ff) begin
               // rewrite the armed target's entry in place
               mem_we          = 1'b1;
               armed_target_in = 8'd0;
               state_in        = ST_SUM;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_WAIT: begin
            if (scale_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               load_match = 1'b1;
               match_in   = match_ff + 1'b1;
               idx_in     = idx_ff + 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_SUM: begin
            if (slot_free) begin
               load_sum = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         armed_target_ff <= 8'd0;
         armed_low_ff    <= 32'sd0;
         armed_high_ff   <= ARM_HIGH_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         armed_target_ff <= armed_target_in;
         armed_low_ff    <= armed_low_in;
         armed_high_ff   <= armed_high_in;
         if (load_match || load_sum) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      idx_ff    <= idx_in;
      match_ff  <= match_in;
      sum_ok_ff <= sum_ok_in;
      // hold the beat for the walk
      if (accept) begin
         op_ff    <= req_func;
         chan_ff  <= req_channel;
         ctrl_ff  <= req_ctrl_number;
         value_ff <= req_ctrl_value;
      end
      if (load_match) begin
         rsp_is_summary_ff   <= 1'b0;
         rsp_out_target_ff   <= rd_data_ff.target;
         rsp_scaled_value_ff <= scale_rsp.result;
         rsp_match_count_ff  <= 5'd0;
         rsp_ok_ff           <= 1'b1;
         rsp_last_ff         <= 1'b0;
      end else if (load_sum) begin
         rsp_is_summary_ff   <= 1'b1;
         rsp_out_target_ff   <= 8'd0;
         rsp_scaled_value_ff <= 32'sd0;
         rsp_match_count_ff  <= match_ff;
         rsp_ok_ff           <= sum_ok_ff;
         rsp_last_ff         <= 1'b1;
      end
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_mem[idx_ff[IDX_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_summary   = rsp_is_summary_ff;
   assign rsp_out_target   = rsp_out_target_ff;
   assign rsp_scaled_value = rsp_scaled_value_ff;
   assign rsp_match_count  = rsp_match_count_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_last         = rsp_last_ff;

   // fill never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table size");

   // scaler finishes only while the walk waits for it
   a_scale_done: assert property (@(posedge clock) disable iff (reset)
      scale_rsp.done |-> state_ff == ST_WAIT)
      else $error("scaler result with no walk waiting");

   // table writes come only from a learn with an armed target
   a_write_learn: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (op_ff == FUNC_LEARN && armed_target_ff != 8'd0))
      else $error("table write outside an armed learn");

   // a summary beat closes the item and a match beat never does
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_is_summary_ff == rsp_last_ff)
      else $error("summary and last flags disagree");

   // a beat is loaded only into a free output slot
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (load_match || load_sum) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten");

endmodule
